@@ design/epoch_seconds_to_calendar_top_assert.svh @@
// assertion macros for the epoch seconds to calendar block
// used by the checker module; depends on nothing else
`ifndef EPOCH_SECONDS_TO_CALENDAR_TOP_ASSERT_SVH
`define EPOCH_SECONDS_TO_CALENDAR_TOP_ASSERT_SVH

// same-cycle implication
`define ESC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ESC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/esc_pkg.sv @@
// types, constants and helper functions for the epoch seconds to calendar block
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package esc_pkg;

    localparam int SECS_W  = 32;
    localparam int YEAR_W  = 12;
    localparam int MONTH_W = 4;
    localparam int DOM_W   = 5;
    localparam int HOUR_W  = 5;
    localparam int MIN_W   = 6;
    localparam int SEC_W   = 6;
    localparam int WDAY_W  = 3;
    localparam int DAYS_W  = 16;
    localparam int CNT_W   = 4;

    localparam logic [SECS_W-1:0]  DAY_SECS  = 32'd86400;
    localparam logic [SECS_W-1:0]  HOUR_SECS = 32'd3600;
    localparam logic [SECS_W-1:0]  MIN_SECS  = 32'd60;
    localparam logic [SECS_W-1:0]  WEEK_LEN  = 32'd7;
    localparam logic [YEAR_W-1:0]  YEAR_BASE = 12'd1970;
    // the only century in range that is not a leap year
    localparam logic [YEAR_W-1:0]  YEAR_SKIP = 12'd2100;
    localparam logic [MONTH_W-1:0] MONTHS    = 4'd12;
    // 1970-01-01 was a thursday, sunday counts as zero
    localparam logic [SECS_W-1:0]  WDAY_OFS  = 32'd4;

    localparam logic [CNT_W-1:0] DAYS_LAST = 4'd15;
    localparam logic [CNT_W-1:0] HOUR_LAST = 4'd4;
    localparam logic [CNT_W-1:0] MIN_LAST  = 4'd5;
    localparam logic [CNT_W-1:0] WDAY_LAST = 4'd12;

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_DAYS = 7'b0000010,
        S_HOUR = 7'b0000100,
        S_MIN  = 7'b0001000,
        S_WDAY = 7'b0010000,
        S_YEAR = 7'b0100000,
        S_MON  = 7'b1000000
    } t_state;

    function automatic logic is_leap(input logic [YEAR_W-1:0] y);
        return (y[1:0] == 2'b00) && (y != YEAR_SKIP);
    endfunction

    function automatic logic [8:0] year_len(input logic [YEAR_W-1:0] y);
        return is_leap(y) ? 9'd366 : 9'd365;
    endfunction

    function automatic logic [4:0] month_len(input logic [MONTH_W-1:0] m, input logic leap);
        logic [4:0] len;
        unique case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
            4'd2:                                       len = leap ? 5'd29 : 5'd28;
            default:                                    len = 5'd0;
        endcase
        return len;
    endfunction

endpackage

`default_nettype wire

@@ design/epoch_seconds_to_calendar_top.sv @@
// epoch seconds to calendar date, time of day and weekday; one compare-subtract unit
// under a sequencer; depends on esc_pkg
// sequence from request to result strobe: 40 division steps, then a scan of the years since
//   1970 and of the months before the result's, each scan ending in a step of its own
// throughput: one request per conversion; busy stays high until the strobe cycle, which takes the next
// reset: synchronous, active low, clears the sequencer and the strobe
`timescale 1ns / 1ps
`default_nettype none

module epoch_seconds_to_calendar_top (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         start,
    output logic                              busy,
    input  wire logic [esc_pkg::SECS_W-1:0]   i_epoch_seconds,
    output logic                              o_valid,
    output logic      [esc_pkg::YEAR_W-1:0]   o_year,
    output logic      [esc_pkg::MONTH_W-1:0]  o_month,
    output logic      [esc_pkg::DOM_W-1:0]    o_day_of_month,
    output logic      [esc_pkg::HOUR_W-1:0]   o_hour,
    output logic      [esc_pkg::MIN_W-1:0]    o_minute,
    output logic      [esc_pkg::SEC_W-1:0]    o_second,
    output logic      [esc_pkg::WDAY_W-1:0]   o_weekday
);
    import esc_pkg::*;

    t_state              r_state, n_state;
    logic                r_valid, n_valid;
    logic [SECS_W-1:0]   r_rem,   n_rem;
    logic [CNT_W-1:0]    r_cnt,   n_cnt;
    logic [DAYS_W-2:0]   r_q,     n_q;
    logic [DAYS_W-1:0]   r_days,  n_days;
    logic [YEAR_W-1:0]   r_year,  n_year;
    logic [MONTH_W-1:0]  r_mon,   n_mon;
    logic [DOM_W-1:0]    r_dom,   n_dom;
    logic [HOUR_W-1:0]   r_hour,  n_hour;
    logic [MIN_W-1:0]    r_min,   n_min;
    logic [SEC_W-1:0]    r_sec,   n_sec;
    logic [WDAY_W-1:0]   r_wday,  n_wday;

    logic [SECS_W-1:0]   w_opnd;
    logic [SECS_W-1:0]   w_diff;
    logic [SECS_W-1:0]   w_rem_nxt;
    logic                w_ge;
    logic [DAYS_W-1:0]   w_q_nxt;

    // shared compare-subtract unit
    always_comb begin
        unique case (r_state)
            S_DAYS:  w_opnd = DAY_SECS  << r_cnt;
            S_HOUR:  w_opnd = HOUR_SECS << r_cnt;
            S_MIN:   w_opnd = MIN_SECS  << r_cnt;
            S_WDAY:  w_opnd = WEEK_LEN  << r_cnt;
            S_YEAR:  w_opnd = {23'd0, year_len(r_year)};
            S_MON:   w_opnd = {27'd0, month_len(r_mon, is_leap(r_year))};
            default: w_opnd = '0;
        endcase
    end

    assign w_ge      = (r_rem >= w_opnd);
    assign w_diff    = r_rem - w_opnd;
    assign w_rem_nxt = w_ge ? w_diff : r_rem;
    assign w_q_nxt   = {r_q, w_ge};

    // sequencer
    always_comb begin
        n_state = r_state;
        n_valid = 1'b0;
        n_rem   = r_rem;
        n_cnt   = r_cnt;
        n_q     = r_q;
        n_days  = r_days;
        n_year  = r_year;
        n_mon   = r_mon;
        n_dom   = r_dom;
        n_hour  = r_hour;
        n_min   = r_min;
        n_sec   = r_sec;
        n_wday  = r_wday;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_rem   = i_epoch_seconds;
                    n_cnt   = DAYS_LAST;
                    n_state = S_DAYS;
                end
            end
            S_DAYS: begin
                n_rem = w_rem_nxt;
                n_q   = w_q_nxt[DAYS_W-2:0];
                n_cnt = r_cnt - 4'd1;
                if (r_cnt == '0) begin
                    n_days  = w_q_nxt;
                    n_cnt   = HOUR_LAST;
                    n_state = S_HOUR;
                end
            end
            S_HOUR: begin
                n_rem = w_rem_nxt;
                n_q   = w_q_nxt[DAYS_W-2:0];
                n_cnt = r_cnt - 4'd1;
                if (r_cnt == '0) begin
                    n_hour  = w_q_nxt[HOUR_W-1:0];
                    n_cnt   = MIN_LAST;
                    n_state = S_MIN;
                end
            end
            S_MIN: begin
                n_rem = w_rem_nxt;
                n_q   = w_q_nxt[DAYS_W-2:0];
                n_cnt = r_cnt - 4'd1;
                if (r_cnt == '0) begin
                    n_min   = w_q_nxt[MIN_W-1:0];
                    n_sec   = w_rem_nxt[SEC_W-1:0];
                    n_rem   = {16'd0, r_days} + WDAY_OFS;
                    n_cnt   = WDAY_LAST;
                    n_state = S_WDAY;
                end
            end
            S_WDAY: begin
                n_rem = w_rem_nxt;
                n_cnt = r_cnt - 4'd1;
                if (r_cnt == '0) begin
                    n_wday  = w_rem_nxt[WDAY_W-1:0] + 3'd1;
                    n_rem   = {16'd0, r_days};
                    n_year  = YEAR_BASE;
                    n_state = S_YEAR;
                end
            end
            S_YEAR: begin
                if (w_ge) begin
                    n_rem  = w_diff;
                    n_year = r_year + 12'd1;
                end else begin
                    n_mon   = 4'd1;
                    n_state = S_MON;
                end
            end
            S_MON: begin
                if (w_ge && r_mon != MONTHS) begin
                    n_rem = w_diff;
                    n_mon = r_mon + 4'd1;
                end else begin
                    n_dom   = r_rem[DOM_W-1:0] + 5'd1;
                    n_valid = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem  <= n_rem;
        r_cnt  <= n_cnt;
        r_q    <= n_q;
        r_days <= n_days;
        r_year <= n_year;
        r_mon  <= n_mon;
        r_dom  <= n_dom;
        r_hour <= n_hour;
        r_min  <= n_min;
        r_sec  <= n_sec;
        r_wday <= n_wday;
    end

    assign busy           = (r_state != S_IDLE);
    assign o_valid        = r_valid;
    assign o_year         = r_year;
    assign o_month        = r_mon;
    assign o_day_of_month = r_dom;
    assign o_hour         = r_hour;
    assign o_minute       = r_min;
    assign o_second       = r_sec;
    assign o_weekday      = r_wday;

endmodule

`default_nettype wire

@@ design/esc_check.sv @@
// port-level checker for epoch_seconds_to_calendar_top, bound to the top level
// depends on esc_pkg and epoch_seconds_to_calendar_top_assert.svh
`timescale 1ns / 1ps
`default_nettype none

`include "epoch_seconds_to_calendar_top_assert.svh"

module esc_check (
    input wire logic                         i_clk,
    input wire logic                         i_rst_n,
    input wire logic                         start,
    input wire logic                         busy,
    input wire logic                         o_valid,
    input wire logic [esc_pkg::YEAR_W-1:0]   o_year,
    input wire logic [esc_pkg::MONTH_W-1:0]  o_month,
    input wire logic [esc_pkg::DOM_W-1:0]    o_day_of_month,
    input wire logic [esc_pkg::HOUR_W-1:0]   o_hour,
    input wire logic [esc_pkg::MIN_W-1:0]    o_minute,
    input wire logic [esc_pkg::SEC_W-1:0]    o_second,
    input wire logic [esc_pkg::WDAY_W-1:0]   o_weekday
);
    import esc_pkg::*;

    logic w_req;
    logic w_fields_ok;

    assign w_req = start && !busy;
    assign w_fields_ok = (o_year >= YEAR_BASE) && (o_month >= 4'd1) && (o_month <= MONTHS)
                      && (o_day_of_month != 5'd0) && (o_hour < 5'd24)
                      && (o_minute < 6'd60) && (o_second < 6'd60)
                      && (o_weekday != 3'd0);

    `ESC_ASSERT_NEXT(a_req_sets_busy, i_clk, i_rst_n, w_req, busy, "request did not raise busy")
    `ESC_ASSERT_NOW(a_strobe_idle, i_clk, i_rst_n, o_valid, !busy, "result strobe while busy")
    `ESC_ASSERT_NOW(a_strobe_after_busy, i_clk, i_rst_n, o_valid, $past(busy), "strobe without work")
    `ESC_ASSERT_NEXT(a_strobe_single, i_clk, i_rst_n, o_valid, !o_valid, "result strobe repeated")
    `ESC_ASSERT_NOW(a_fields_range, i_clk, i_rst_n, o_valid, w_fields_ok, "result out of range")

endmodule

bind epoch_seconds_to_calendar_top esc_check u_esc_check (.*);

`default_nettype wire

@@ bench/tb_epoch_seconds_to_calendar_top.sv @@
// self-checking bench for epoch_seconds_to_calendar_top: date, time and weekday per request
// predicts each result with calendar_of and checks it in a scoreboard class; depends on esc_pkg and the block
`timescale 1ns / 1ps

module tb_epoch_seconds_to_calendar_top;

    import esc_pkg::*;

    typedef struct packed {
        logic [YEAR_W-1:0]  year;
        logic [MONTH_W-1:0] month;
        logic [DOM_W-1:0]   dom;
        logic [HOUR_W-1:0]  hour;
        logic [MIN_W-1:0]   minute;
        logic [SEC_W-1:0]   second;
        logic [WDAY_W-1:0]  wday;
    } t_calendar;

    localparam longint MAX_SECS = 64'hFFFF_FFFF;

    function automatic bit leap_year(input int unsigned y);
        return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    function automatic int unsigned days_in_month(input int unsigned m, input int unsigned y);
        int unsigned n;
        case (m)
            4, 6, 9, 11: n = 30;
            2:           n = leap_year(y) ? 29 : 28;
            default:     n = 31;
        endcase
        return n;
    endfunction

    // date, time of day and weekday for a count of seconds since 1970
    function automatic t_calendar calendar_of(input logic [SECS_W-1:0] secs);
        t_calendar r;
        int unsigned days, sod, y, m, d, zm, zy, k, j, h;
        days = secs / 86400;
        sod  = secs % 86400;
        y = 1970;
        m = 1;
        while (days >= (leap_year(y) ? 366 : 365)) begin
            days -= leap_year(y) ? 366 : 365;
            y++;
        end
        while (m <= 12 && days >= days_in_month(m, y)) begin
            days -= days_in_month(m, y);
            m++;
        end
        d  = days + 1;
        zm = (m < 3) ? m + 12 : m;
        zy = (m < 3) ? y - 1 : y;
        k  = zy % 100;
        j  = zy / 100;
        h  = (d + (13 * (zm + 1)) / 5 + k + k / 4 + j / 4 + 5 * j) % 7;
        r.year   = y[YEAR_W-1:0];
        r.month  = m[MONTH_W-1:0];
        r.dom    = d[DOM_W-1:0];
        r.hour   = 5'(sod / 3600);
        r.minute = 6'((sod % 3600) / 60);
        r.second = 6'(sod % 60);
        r.wday   = 3'(((h + 6) % 7) + 1);
        return r;
    endfunction

    // seconds since 1970 for a date and time
    function automatic longint seconds_at(input int y, input int m, input int d,
                                          input int hh, input int mm, input int ss);
        longint days;
        days = 0;
        for (int yy = 1970; yy < y; yy++) days += leap_year(yy) ? 366 : 365;
        for (int mo = 1; mo < m; mo++) days += days_in_month(mo, y);
        days += d - 1;
        return days * 86400 + hh * 3600 + mm * 60 + ss;
    endfunction

    class t_calendar_scoreboard;
        t_calendar pending[$];
        int errors;
        int checked;

        function void note(input t_calendar want);
            pending.push_back(want);
        endfunction

        function void field(input string name, input int want, input int got);
            if (want != got) begin
                errors++;
                $error("%s: expected %0d, got %0d", name, want, got);
            end
        endfunction

        function void check(input t_calendar got);
            t_calendar want;
            if (pending.size() == 0) begin
                errors++;
                $error("result with no request outstanding");
                return;
            end
            want = pending.pop_front();
            checked++;
            field("year", want.year, got.year);
            field("month", want.month, got.month);
            field("day_of_month", want.dom, got.dom);
            field("hour", want.hour, got.hour);
            field("minute", want.minute, got.minute);
            field("second", want.second, got.second);
            field("weekday", want.wday, got.wday);
        endfunction
    endclass

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 start = 1'b0;
    logic [SECS_W-1:0]    i_epoch_seconds = '0;
    logic                 busy;
    logic                 o_valid;
    logic [YEAR_W-1:0]    o_year;
    logic [MONTH_W-1:0]   o_month;
    logic [DOM_W-1:0]     o_day_of_month;
    logic [HOUR_W-1:0]    o_hour;
    logic [MIN_W-1:0]     o_minute;
    logic [SEC_W-1:0]     o_second;
    logic [WDAY_W-1:0]    o_weekday;

    t_calendar_scoreboard ledger = new();
    int sent;

    epoch_seconds_to_calendar_top dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_epoch_seconds (i_epoch_seconds),
        .o_valid         (o_valid),
        .o_year          (o_year),
        .o_month         (o_month),
        .o_day_of_month  (o_day_of_month),
        .o_hour          (o_hour),
        .o_minute        (o_minute),
        .o_second        (o_second),
        .o_weekday       (o_weekday)
    );

    always #4 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            ledger.check({o_year, o_month, o_day_of_month, o_hour, o_minute, o_second,
                          o_weekday});
        end
    end

    initial begin
        #20_000_000;
        $display("tb_epoch_seconds_to_calendar_top: errors");
        $finish;
    end

    // one request, then an optional idle gap
    task automatic send(input logic [SECS_W-1:0] secs, input int idle_pct);
        start           <= 1'b1;
        i_epoch_seconds <= secs;
        do @(posedge i_clk); while (busy);
        ledger.note(calendar_of(secs));
        sent++;
        if ($urandom_range(99) < idle_pct) begin
            start           <= 1'b0;
            i_epoch_seconds <= $urandom;
            do @(posedge i_clk); while ($urandom_range(99) < idle_pct);
        end
    endtask

    function automatic logic [SECS_W-1:0] clamp(input longint v);
        if (v < 0) return '0;
        if (v > MAX_SECS) return '1;
        return v[SECS_W-1:0];
    endfunction

    // calendar edges and uniform values in equal parts, the rest near the ends of the range
    function automatic logic [SECS_W-1:0] pick_seconds();
        int sel, y, m, d;
        longint t;
        sel = $urandom_range(99);
        if (sel < 40) return $urandom;
        if (sel < 80) begin
            y = $urandom_range(2105, 1970);
            m = $urandom_range(12, 1);
            d = $urandom_range(1) ? 1 : days_in_month(m, y);
            case ($urandom_range(2))
                0:       t = seconds_at(y, m, d, 0, 0, 0);
                1:       t = seconds_at(y, m, d, 23, 59, 59);
                default: t = seconds_at(y, m, d, 0, 0, 0) + $urandom_range(86399);
            endcase
            return clamp(t + $urandom_range(2) - 1);
        end
        if (sel < 90) return '1 - $urandom_range(4_000_000);
        return $urandom_range(86400 * 800);
    endfunction

    initial begin
        longint directed[$];
        int idle_pct[3];
        idle_pct = '{37, 72, 0};
        directed = '{0, 1, 59, 60, 3599, 3600, 86399, 86400,
                     seconds_at(1972, 2, 29, 12, 0, 0),
                     seconds_at(1972, 12, 31, 23, 59, 59),
                     seconds_at(1999, 1, 3, 8, 30, 0),
                     seconds_at(2000, 2, 29, 0, 0, 0),
                     seconds_at(2000, 3, 1, 0, 0, 0) - 1,
                     seconds_at(2000, 12, 31, 23, 59, 59),
                     seconds_at(2001, 1, 1, 0, 0, 0),
                     seconds_at(2024, 2, 17, 18, 45, 30),
                     64'h7FFF_FFFF, 64'h8000_0000,
                     seconds_at(2099, 12, 31, 23, 59, 59),
                     seconds_at(2100, 2, 28, 23, 59, 59),
                     seconds_at(2100, 3, 1, 0, 0, 0),
                     seconds_at(2106, 2, 7, 0, 0, 0),
                     64'hAAAA_AAAA, 64'h5555_5555, MAX_SECS};
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        foreach (directed[i]) send(clamp(directed[i]), idle_pct[0]);
        foreach (idle_pct[p]) begin
            repeat (640) send(pick_seconds(), idle_pct[p]);
        end
        start <= 1'b0;
        while (ledger.pending.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        $display("%0d requests sent: calendar edges, leap and century years, range ends",
                 sent);
        $display("%0d results checked field by field", ledger.checked);
        if (ledger.errors == 0) begin
            $display("tb_epoch_seconds_to_calendar_top: clean");
        end else begin
            $display("tb_epoch_seconds_to_calendar_top: errors");
        end
        $finish;
    end

endmodule
